@@ src/aim_pkg.sv @@
// Shared types and fixed widths for the affine 3x4 matrix inverse.
// Used by aim_div and affine_3x4_matrix_inverse; depends on nothing.
package aim_pkg;
	localparam int ELEM_W    = 32;
	localparam int ADJ_MAG_W = 64;
	localparam int DET_MAG_W = 96;
	localparam int QUO_W     = 34;
	localparam int DIV_LAT   = QUO_W + 2;

	typedef logic signed [ELEM_W-1:0] elem_t;

	localparam elem_t ELEM_MAX = 32'sh7fffffff;
	localparam elem_t ELEM_MIN = 32'sh80000000;

	typedef struct packed {
		logic                 neg;
		logic [ADJ_MAG_W-1:0] num;
		logic [DET_MAG_W-1:0] den;
	} div_req_t;
endpackage

@@ src/affine_3x4_matrix_inverse.sv @@
// Affine 3x4 matrix inverse in signed fixed point, adjugate over determinant.
// Throughput one request per cycle while the pipeline is not halted by out_stall.
// The divider pipeline (34 quotient stages) sets the depth; the whole pipeline halts
// while a result waits under out_stall. arst_n clears all valid bits; data is not reset.
// Depends on aim_pkg and aim_div.
module affine_3x4_matrix_inverse #(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  aim_pkg::elem_t a_r1c1,
	input  aim_pkg::elem_t a_r1c2,
	input  aim_pkg::elem_t a_r1c3,
	input  aim_pkg::elem_t a_r1_shift,
	input  aim_pkg::elem_t a_r2c1,
	input  aim_pkg::elem_t a_r2c2,
	input  aim_pkg::elem_t a_r2c3,
	input  aim_pkg::elem_t a_r2_shift,
	input  aim_pkg::elem_t a_r3c1,
	input  aim_pkg::elem_t a_r3c2,
	input  aim_pkg::elem_t a_r3c3,
	input  aim_pkg::elem_t a_r3_shift,
	output logic           out_valid,
	input  logic           out_stall,
	output aim_pkg::elem_t b_r1c1,
	output aim_pkg::elem_t b_r1c2,
	output aim_pkg::elem_t b_r1c3,
	output aim_pkg::elem_t b_r1_shift,
	output aim_pkg::elem_t b_r2c1,
	output aim_pkg::elem_t b_r2c2,
	output aim_pkg::elem_t b_r2c3,
	output aim_pkg::elem_t b_r2_shift,
	output aim_pkg::elem_t b_r3c1,
	output aim_pkg::elem_t b_r3c2,
	output aim_pkg::elem_t b_r3c3,
	output aim_pkg::elem_t b_r3_shift
);
	import aim_pkg::*;

	localparam logic [66:0] HALF = 67'(1) << (FRAC_BITS - 1);

	logic en;

	elem_t              a_s1 [3][3];
	elem_t              s_s1 [3];
	logic               v_s1;
	logic signed [63:0] p0_s2 [3][3];
	logic signed [63:0] p1_s2 [3][3];
	elem_t              a0_s2 [3];
	elem_t              s_s2 [3];
	logic               v_s2;
	logic signed [64:0] adj_s3 [3][3];
	elem_t              a0_s3 [3];
	elem_t              s_s3 [3];
	logic               v_s3;
	logic signed [64:0] ph_s4 [3];
	logic signed [64:0] pl_s4 [3];
	logic signed [64:0] adj_s4 [3][3];
	elem_t              s_s4 [3];
	logic               v_s4;
	logic signed [97:0] term_s5 [3];
	logic signed [64:0] adj_s5 [3][3];
	elem_t              s_s5 [3];
	logic               v_s5;
	logic signed [97:0] det_s6;
	logic signed [64:0] adj_s6 [3][3];
	elem_t              s_s6 [3];
	logic               v_s6;
	logic [DET_MAG_W-1:0] dmag_s7;
	logic               dneg_s7;
	logic               dz_s7;
	logic [ADJ_MAG_W-1:0] amag_s7 [3][3];
	logic               aneg_s7 [3][3];
	elem_t              s_s7 [3];
	logic               v_s7;

	logic               v_dv [DIV_LAT];
	logic               dz_dv [DIV_LAT];
	elem_t              s_dv [DIV_LAT][3];
	elem_t              quo [3][3];

	logic signed [63:0] prod_s44 [3][3];
	elem_t              b_s44 [3][3];
	logic               dz_s44;
	logic               v_s44;
	logic signed [66:0] t_s45 [3];
	elem_t              b_s45 [3][3];
	logic               dz_s45;
	logic               v_s45;
	logic [66:0]        tmag_s46 [3];
	logic               tneg_s46 [3];
	elem_t              b_s46 [3][3];
	logic               dz_s46;
	logic               v_s46;
	elem_t              bo_s47 [3][4];
	logic               v_s47;

	logic signed [97:0] det_abs;
	logic signed [64:0] adj_abs [3][3];
	logic [66:0]        rq [3];

	// hold every stage while the output register is full and held
	assign en        = !(v_s47 && out_stall);
	assign in_stall  = !en;
	assign out_valid = v_s47;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			for (int k = 0; k < DIV_LAT; k++) v_dv[k] <= 1'b0;
			v_s44 <= 1'b0;
			v_s45 <= 1'b0;
			v_s46 <= 1'b0;
			v_s47 <= 1'b0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_dv[0] <= v_s7;
			for (int k = 1; k < DIV_LAT; k++) v_dv[k] <= v_dv[k-1];
			v_s44 <= v_dv[DIV_LAT-1];
			v_s45 <= v_s44;
			v_s46 <= v_s45;
			v_s47 <= v_s46;
		end
	end

	// capture request
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1[0][0] <= a_r1c1;
			a_s1[0][1] <= a_r1c2;
			a_s1[0][2] <= a_r1c3;
			a_s1[1][0] <= a_r2c1;
			a_s1[1][1] <= a_r2c2;
			a_s1[1][2] <= a_r2c3;
			a_s1[2][0] <= a_r3c1;
			a_s1[2][1] <= a_r3c2;
			a_s1[2][2] <= a_r3c3;
			s_s1[0]    <= a_r1_shift;
			s_s1[1]    <= a_r2_shift;
			s_s1[2]    <= a_r3_shift;
		end
	end

	// cofactor products and differences
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					p0_s2[i][j] <= a_s1[(j+1)%3][(i+1)%3] * a_s1[(j+2)%3][(i+2)%3];
					p1_s2[i][j] <= a_s1[(j+1)%3][(i+2)%3] * a_s1[(j+2)%3][(i+1)%3];
					adj_s3[i][j] <= 65'(p0_s2[i][j]) - 65'(p1_s2[i][j]);
				end
				a0_s2[i] <= a_s1[0][i];
				a0_s3[i] <= a0_s2[i];
				s_s2[i]  <= s_s1[i];
				s_s3[i]  <= s_s2[i];
			end
		end
	end

	// determinant: split each cofactor into high and low halves to keep multipliers narrow
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				ph_s4[k]   <= a0_s3[k] * $signed(adj_s3[k][0][64:32]);
				pl_s4[k]   <= a0_s3[k] * $signed({1'b0, adj_s3[k][0][31:0]});
				term_s5[k] <= (98'(ph_s4[k]) <<< 32) + 98'(pl_s4[k]);
				s_s4[k]    <= s_s3[k];
				s_s5[k]    <= s_s4[k];
				s_s6[k]    <= s_s5[k];
				s_s7[k]    <= s_s6[k];
			end
			det_s6 <= term_s5[0] + term_s5[1] + term_s5[2];
			adj_s4 <= adj_s3;
			adj_s5 <= adj_s4;
			adj_s6 <= adj_s5;
		end
	end

	always_comb begin
		det_abs = det_s6[97] ? -det_s6 : det_s6;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				adj_abs[i][j] = adj_s6[i][j][64] ? -adj_s6[i][j] : adj_s6[i][j];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dmag_s7 <= det_abs[DET_MAG_W-1:0];
			dneg_s7 <= det_s6[97];
			dz_s7   <= det_s6 == '0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					amag_s7[i][j] <= adj_abs[i][j][ADJ_MAG_W-1:0];
					aneg_s7[i][j] <= adj_s6[i][j][64];
				end
			end
		end
	end

	for (genvar gi = 0; gi < 3; gi++) begin : g_row
		for (genvar gj = 0; gj < 3; gj++) begin : g_col
			div_req_t req;
			assign req.neg = aneg_s7[gi][gj] ^ dneg_s7;
			assign req.num = amag_s7[gi][gj];
			assign req.den = dmag_s7;
			aim_div #(
				.FRAC_BITS(FRAC_BITS)
			) u_div (
				.clk(clk),
				.en (en),
				.req(req),
				.quo(quo[gi][gj])
			);
		end
	end

	// carry the translation and singular flag alongside the divider
	always_ff @(posedge clk) begin
		if (en) begin
			dz_dv[0] <= dz_s7;
			s_dv[0]  <= s_s7;
			for (int k = 1; k < DIV_LAT; k++) begin
				dz_dv[k] <= dz_dv[k-1];
				s_dv[k]  <= s_dv[k-1];
			end
		end
	end

	// translation: t = -(B * s), rounded to nearest, ties away from zero
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					prod_s44[i][j] <= quo[i][j] * s_dv[DIV_LAT-1][j];
			b_s44  <= quo;
			dz_s44 <= dz_dv[DIV_LAT-1];
			for (int i = 0; i < 3; i++)
				t_s45[i] <= 67'(0) - 67'(prod_s44[i][0]) - 67'(prod_s44[i][1])
					- 67'(prod_s44[i][2]);
			b_s45  <= b_s44;
			dz_s45 <= dz_s44;
			for (int i = 0; i < 3; i++) begin
				tmag_s46[i] <= t_s45[i][66] ? 67'(-t_s45[i]) : 67'(t_s45[i]);
				tneg_s46[i] <= t_s45[i][66];
			end
			b_s46  <= b_s45;
			dz_s46 <= dz_s45;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++)
			rq[i] = (tmag_s46[i] + HALF) >> FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++)
					bo_s47[i][j] <= dz_s46 ? '0 : b_s46[i][j];
				if (dz_s46)
					bo_s47[i][3] <= '0;
				else if (tneg_s46[i])
					bo_s47[i][3] <= (rq[i] > 67'(33'h080000000)) ? ELEM_MIN
						: -$signed(rq[i][ELEM_W-1:0]);
				else
					bo_s47[i][3] <= (rq[i] > 67'(33'h07fffffff)) ? ELEM_MAX
						: $signed(rq[i][ELEM_W-1:0]);
			end
		end
	end

	assign b_r1c1     = bo_s47[0][0];
	assign b_r1c2     = bo_s47[0][1];
	assign b_r1c3     = bo_s47[0][2];
	assign b_r1_shift = bo_s47[0][3];
	assign b_r2c1     = bo_s47[1][0];
	assign b_r2c2     = bo_s47[1][1];
	assign b_r2c3     = bo_s47[1][2];
	assign b_r2_shift = bo_s47[1][3];
	assign b_r3c1     = bo_s47[2][0];
	assign b_r3c2     = bo_s47[2][1];
	assign b_r3c3     = bo_s47[2][2];
	assign b_r3_shift = bo_s47[2][3];
endmodule

@@ src/aim_div.sv @@
// Pipelined restoring divider: round(cofactor * 2^(2F) / det), saturated to 32 bits.
// One quotient bit per stage; depends on aim_pkg.
module aim_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              en,
	input  aim_pkg::div_req_t req,
	output aim_pkg::elem_t    quo
);
	import aim_pkg::*;

	localparam int REM_W = DET_MAG_W + QUO_W;

	logic [REM_W-1:0]     rem_s [QUO_W+1];
	logic [DET_MAG_W-1:0] den_s [QUO_W+1];
	logic [QUO_W-1:0]     q_s   [QUO_W+1];
	logic                 neg_s [QUO_W+1];
	logic                 ovf_s [QUO_W+1];
	logic [REM_W-1:0]     num_ext;
	logic [QUO_W:0]       rnd;
	elem_t                quo_q;

	// twice the numerator, so the last quotient bit is the rounding bit
	assign num_ext = REM_W'(req.num) << (2 * FRAC_BITS + 1);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num_ext;
			den_s[0] <= req.den;
			q_s[0]   <= '0;
			neg_s[0] <= req.neg;
			ovf_s[0] <= num_ext >= {req.den, QUO_W'(0)};
		end
	end

	for (genvar i = 0; i < QUO_W; i++) begin : g_step
		localparam int SH = QUO_W - 1 - i;
		logic [REM_W-1:0] dsh;
		logic             take;
		assign dsh  = REM_W'(den_s[i]) << SH;
		assign take = rem_s[i] >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= take ? rem_s[i] - dsh : rem_s[i];
				den_s[i+1] <= den_s[i];
				q_s[i+1]   <= {q_s[i][QUO_W-2:0], take};
				neg_s[i+1] <= neg_s[i];
				ovf_s[i+1] <= ovf_s[i];
			end
		end
	end

	assign rnd = ({1'b0, q_s[QUO_W]} + (QUO_W+1)'(1)) >> 1;

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s[QUO_W]) begin
				if (ovf_s[QUO_W] || rnd > (QUO_W+1)'(33'h080000000))
					quo_q <= ELEM_MIN;
				else
					quo_q <= -$signed(rnd[ELEM_W-1:0]);
			end else begin
				if (ovf_s[QUO_W] || rnd > (QUO_W+1)'(33'h07fffffff))
					quo_q <= ELEM_MAX;
				else
					quo_q <= $signed(rnd[ELEM_W-1:0]);
			end
		end
	end

	assign quo = quo_q;
endmodule
